>>> design/rmq_pkg.sv
// ----------------------------------------------------------------------------
// rmq_pkg: rotation matrix to quaternion shared definitions
// Fixed-point formats, pipeline depths and sideband types used across the
// datapath units and the top level.
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int FRAC_BITS = 30;

  // matrix entry and derived widths
  localparam int M_W = 32;
  localparam int D_W = M_W + 2;          // diagonal terms, signed
  localparam int N_W = M_W + 1;          // off-diagonal sums and differences

  // integer square root unit
  localparam int SQ_IN_W  = 64;
  localparam int SQ_OUT_W = SQ_IN_W / 2;
  localparam int SQ_LAT   = SQ_OUT_W;    // one result bit per stage

  // scaled divider unit
  localparam int QM_W    = 32;           // quotient magnitude bits
  localparam int Q_W     = QM_W + 1;     // signed component
  localparam int DIV_N_W = N_W + 1;      // signed numerator
  localparam int DEN_W   = SQ_OUT_W + 2; // four times the chosen component
  localparam int DIV_LAT = QM_W;         // one quotient bit per stage

  localparam int OUT_W = 32;

  // end-to-end latency from accept edge to the edge that samples the strobe
  localparam int PIPE_LAT = 2 * SQ_LAT + 2 * DIV_LAT + 8;

  typedef enum logic [1:0] {
    AX_X = 2'd0,
    AX_Y = 2'd1,
    AX_Z = 2'd2,
    AX_W = 2'd3
  } axis_t;

  typedef logic signed [N_W-1:0] num_t;
  typedef logic signed [Q_W-1:0] comp_t;

  // travels alongside the first square root
  typedef struct packed {
    axis_t        axis;
    num_t [3:0]   num;
  } sqa_sb_t;

  // travels alongside the first divider bank
  typedef struct packed {
    axis_t                 axis;
    logic [SQ_OUT_W-1:0]   chosen;
    logic                  degen;
  } diva_sb_t;

  // travels alongside the length square root
  typedef struct packed {
    comp_t [3:0] q;
    logic        degen;
  } sqb_sb_t;

endpackage

>>> design/rmq_isqrt.sv
// ----------------------------------------------------------------------------
// rmq_isqrt: pipelined integer square root
// Floor square root of a 64-bit value, one result bit per register stage.
// ----------------------------------------------------------------------------
module rmq_isqrt
  import rmq_pkg::*;
(
  input  logic                 clk,
  input  logic [SQ_IN_W-1:0]   rad,
  output logic [SQ_OUT_W-1:0]  root
);

  logic [SQ_IN_W-1:0] rem_r [SQ_LAT];
  logic [SQ_IN_W-1:0] res_r [SQ_LAT];

  for (genvar s = 0; s < SQ_LAT; s++) begin : g_stage
    localparam logic [SQ_IN_W-1:0] PW = SQ_IN_W'(1) << (SQ_IN_W - 2 - 2 * s);
    logic [SQ_IN_W-1:0] rem_in, res_in, trial, rem_nxt, res_nxt;

    if (s == 0) begin : g_first
      assign rem_in = rad;
      assign res_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign res_in = res_r[s-1];
    end

    assign trial = res_in + PW;

    always_comb begin
      if (rem_in >= trial) begin
        rem_nxt = rem_in - trial;
        res_nxt = (res_in >> 1) + PW;
      end else begin
        rem_nxt = rem_in;
        res_nxt = res_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      res_r[s] <= res_nxt;
    end

    // the last remainder is never needed
    if (s < SQ_LAT - 1) begin : g_rem
      always_ff @(posedge clk) begin
        rem_r[s] <= rem_nxt;
      end
    end
  end

  assign root = res_r[SQ_LAT-1][SQ_OUT_W-1:0];

endmodule

>>> design/rmq_div.sv
// ----------------------------------------------------------------------------
// rmq_div: pipelined scaled divider
// Computes (num * 2^FRAC_BITS) / den truncated toward zero, one quotient bit
// per register stage; the sign is applied after the last stage.
// ----------------------------------------------------------------------------
module rmq_div
  import rmq_pkg::*;
(
  input  logic                       clk,
  input  logic signed [DIV_N_W-1:0]  num,
  input  logic [DEN_W-1:0]           den,
  output logic signed [Q_W-1:0]      quo
);

  localparam int REM_W = DIV_N_W + FRAC_BITS;
  localparam int CMP_W = DEN_W + QM_W;

  logic [REM_W-1:0]   rem_r [DIV_LAT];
  logic [DEN_W-1:0]   den_r [DIV_LAT];
  logic [QM_W-1:0]    q_r   [DIV_LAT];
  logic               neg_r [DIV_LAT];
  logic [DIV_N_W-1:0] mag;
  logic signed [Q_W-1:0] qs;

  assign mag = num[DIV_N_W-1] ? (~num + 1'b1) : num;

  for (genvar s = 0; s < DIV_LAT; s++) begin : g_stage
    localparam int B = QM_W - 1 - s;
    logic [REM_W-1:0] rem_in, rem_nxt;
    logic [DEN_W-1:0] den_in;
    logic [QM_W-1:0]  q_in, q_nxt;
    logic             neg_in;
    logic [CMP_W-1:0] sub;
    logic             fit;

    if (s == 0) begin : g_first
      assign rem_in = REM_W'(mag) << FRAC_BITS;
      assign den_in = den;
      assign q_in   = '0;
      assign neg_in = num[DIV_N_W-1];
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign den_in = den_r[s-1];
      assign q_in   = q_r[s-1];
      assign neg_in = neg_r[s-1];
    end

    assign sub     = CMP_W'(den_in) << B;
    assign fit     = CMP_W'(rem_in) >= sub;
    assign rem_nxt = fit ? REM_W'(CMP_W'(rem_in) - sub) : rem_in;
    assign q_nxt   = fit ? (q_in | (QM_W'(1) << B)) : q_in;

    always_ff @(posedge clk) begin
      q_r[s]   <= q_nxt;
      neg_r[s] <= neg_in;
    end

    if (s < DIV_LAT - 1) begin : g_carry
      always_ff @(posedge clk) begin
        rem_r[s] <= rem_nxt;
        den_r[s] <= den_in;
      end
    end
  end

  assign qs  = $signed({1'b0, q_r[DIV_LAT-1]});
  assign quo = neg_r[DIV_LAT-1] ? -qs : qs;

endmodule

>>> design/rotation_matrix_to_quaternion_core.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_core: 3x3 rotation matrix to unit quaternion
// Pipeline: 2 square roots of 32 stages, 2 divider banks of 32 stages and 8
//   glue stages between the accepted item and its result strobe.
// Throughput: one item per cycle; busy never asserts, results cannot stall.
// Reset: synchronous active-low rst_n clears every valid bit; data holds.
// ----------------------------------------------------------------------------
// Pipeline outline:
//   P1  form the four diagonal terms and the six off-diagonal sums/diffs
//   P2  pick the largest term (first wins on a tie), slot the numerators
//   SQ1 chosen component = floor sqrt(term * 2^(F-2))
//   P3  divisor = 4 * chosen, flag a zero divisor
//   DV1 the other three components by scaled division
//   P4  assemble the raw quaternion
//   P5  square each component magnitude
//   P6  sum of squares
//   SQ2 vector length
//   P7  flag a zero length, feed the second divider bank
//   DV2 normalize each component
//   P8  canonical sign, zero on degenerate, register the result
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_core
  import rmq_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [M_W-1:0]   in_m00,
  input  logic signed [M_W-1:0]   in_m01,
  input  logic signed [M_W-1:0]   in_m02,
  input  logic signed [M_W-1:0]   in_m10,
  input  logic signed [M_W-1:0]   in_m11,
  input  logic signed [M_W-1:0]   in_m12,
  input  logic signed [M_W-1:0]   in_m20,
  input  logic signed [M_W-1:0]   in_m21,
  input  logic signed [M_W-1:0]   in_m22,
  output logic                    out_valid,
  output logic signed [OUT_W-1:0] out_qx,
  output logic signed [OUT_W-1:0] out_qy,
  output logic signed [OUT_W-1:0] out_qz,
  output logic signed [OUT_W-1:0] out_qw,
  output logic                    out_degenerate
);

  localparam logic signed [D_W-1:0] ONE_D = D_W'(1) << FRAC_BITS;

  // the pipeline takes an item every cycle
  assign busy = 1'b0;

  // --------------------------------------------------------------------------
  // P1: diagonal terms and off-diagonal sums/differences
  // --------------------------------------------------------------------------
  logic                  v1_r;
  logic signed [D_W-1:0] d1_r [4];
  num_t                  s01_r, s02_r, s12_r;
  num_t                  t1_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    d1_r[0] <= ONE_D + D_W'(in_m00) - D_W'(in_m11) - D_W'(in_m22);
    d1_r[1] <= ONE_D - D_W'(in_m00) + D_W'(in_m11) - D_W'(in_m22);
    d1_r[2] <= ONE_D - D_W'(in_m00) - D_W'(in_m11) + D_W'(in_m22);
    d1_r[3] <= ONE_D + D_W'(in_m00) + D_W'(in_m11) + D_W'(in_m22);
    s01_r   <= N_W'(in_m01) + N_W'(in_m10);
    s02_r   <= N_W'(in_m02) + N_W'(in_m20);
    s12_r   <= N_W'(in_m12) + N_W'(in_m21);
    t1_r[0] <= N_W'(in_m21) - N_W'(in_m12);
    t1_r[1] <= N_W'(in_m02) - N_W'(in_m20);
    t1_r[2] <= N_W'(in_m10) - N_W'(in_m01);
  end

  // --------------------------------------------------------------------------
  // P2: pick the axis, slot numerators, form the square root operand
  // --------------------------------------------------------------------------
  axis_t                 ax_nxt;
  logic signed [D_W-1:0] best;
  num_t [3:0]            num_nxt;
  logic [SQ_IN_W-1:0]    sq_in_nxt;
  logic                  v2_r;
  logic [SQ_IN_W-1:0]    sq_in_r;
  sqa_sb_t               sb2_r;

  always_comb begin
    ax_nxt = AX_X;
    best   = d1_r[0];
    if (d1_r[1] > best) begin
      ax_nxt = AX_Y;
      best   = d1_r[1];
    end
    if (d1_r[2] > best) begin
      ax_nxt = AX_Z;
      best   = d1_r[2];
    end
    if (d1_r[3] > best) begin
      ax_nxt = AX_W;
      best   = d1_r[3];
    end
  end

  // the chosen slot is filled from the square root later
  always_comb begin
    unique case (ax_nxt)
      AX_X: begin
        num_nxt[0] = '0;      num_nxt[1] = s01_r;
        num_nxt[2] = s02_r;   num_nxt[3] = t1_r[0];
      end
      AX_Y: begin
        num_nxt[0] = s01_r;   num_nxt[1] = '0;
        num_nxt[2] = s12_r;   num_nxt[3] = t1_r[1];
      end
      AX_Z: begin
        num_nxt[0] = s02_r;   num_nxt[1] = s12_r;
        num_nxt[2] = '0;      num_nxt[3] = t1_r[2];
      end
      AX_W: begin
        num_nxt[0] = t1_r[0]; num_nxt[1] = t1_r[1];
        num_nxt[2] = t1_r[2]; num_nxt[3] = '0;
      end
      default: begin
        num_nxt = '0;
      end
    endcase
  end

  // clamp a nonpositive term at zero
  assign sq_in_nxt = (best > 0) ? (SQ_IN_W'($unsigned(best)) << (FRAC_BITS - 2)) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    sq_in_r    <= sq_in_nxt;
    sb2_r.axis <= ax_nxt;
    sb2_r.num  <= num_nxt;
  end

  // --------------------------------------------------------------------------
  // SQ1: chosen component, sideband delayed to match
  // --------------------------------------------------------------------------
  logic [SQ_OUT_W-1:0] root1;
  sqa_sb_t             sqa_dl_r [SQ_LAT];
  logic [SQ_LAT-1:0]   sqa_v_r;

  rmq_isqrt u_sq_axis (
    .clk  (clk),
    .rad  (sq_in_r),
    .root (root1)
  );

  always_ff @(posedge clk) begin
    sqa_dl_r[0] <= sb2_r;
    for (int k = 1; k < SQ_LAT; k++) begin
      sqa_dl_r[k] <= sqa_dl_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sqa_v_r <= '0;
    end else begin
      sqa_v_r <= {sqa_v_r[SQ_LAT-2:0], v2_r};
    end
  end

  // --------------------------------------------------------------------------
  // P3: divisor and degenerate check
  // --------------------------------------------------------------------------
  logic                      v3_r;
  logic [DEN_W-1:0]          den3_r;
  logic signed [DIV_N_W-1:0] num3_r [4];
  diva_sb_t                  sb3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= sqa_v_r[SQ_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    den3_r       <= {root1, 2'b00};
    sb3_r.axis   <= sqa_dl_r[SQ_LAT-1].axis;
    sb3_r.chosen <= root1;
    sb3_r.degen  <= (root1 == '0);
    for (int c = 0; c < 4; c++) begin
      num3_r[c] <= DIV_N_W'($signed(sqa_dl_r[SQ_LAT-1].num[c]));
    end
  end

  // --------------------------------------------------------------------------
  // DV1: remaining components
  // --------------------------------------------------------------------------
  comp_t              quo1 [4];
  diva_sb_t           dva_dl_r [DIV_LAT];
  logic [DIV_LAT-1:0] dva_v_r;

  for (genvar c = 0; c < 4; c++) begin : g_div_raw
    rmq_div u_div (
      .clk (clk),
      .num (num3_r[c]),
      .den (den3_r),
      .quo (quo1[c])
    );
  end

  always_ff @(posedge clk) begin
    dva_dl_r[0] <= sb3_r;
    for (int k = 1; k < DIV_LAT; k++) begin
      dva_dl_r[k] <= dva_dl_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dva_v_r <= '0;
    end else begin
      dva_v_r <= {dva_v_r[DIV_LAT-2:0], v3_r};
    end
  end

  // --------------------------------------------------------------------------
  // P4: assemble the raw quaternion
  // --------------------------------------------------------------------------
  logic  v4_r;
  comp_t q4_r [4];
  logic  degen4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= dva_v_r[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    degen4_r <= dva_dl_r[DIV_LAT-1].degen;
    for (int c = 0; c < 4; c++) begin
      if (dva_dl_r[DIV_LAT-1].axis == axis_t'(2'(c))) begin
        q4_r[c] <= $signed({1'b0, dva_dl_r[DIV_LAT-1].chosen});
      end else begin
        q4_r[c] <= quo1[c];
      end
    end
  end

  // --------------------------------------------------------------------------
  // P5: square each magnitude
  // --------------------------------------------------------------------------
  logic [QM_W-1:0]   mag4 [4];
  logic              v5_r;
  comp_t             q5_r [4];
  logic              degen5_r;
  logic [2*QM_W-1:0] sq5_r [4];

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      mag4[c] = q4_r[c][Q_W-1] ? QM_W'(-q4_r[c]) : QM_W'(q4_r[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    degen5_r <= degen4_r;
    for (int c = 0; c < 4; c++) begin
      q5_r[c]  <= q4_r[c];
      sq5_r[c] <= mag4[c] * mag4[c];
    end
  end

  // --------------------------------------------------------------------------
  // P6: sum of squares, wraps at 64 bits
  // --------------------------------------------------------------------------
  logic               v6_r;
  logic [SQ_IN_W-1:0] sum6_r;
  sqb_sb_t            sb6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else begin
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    sum6_r      <= SQ_IN_W'(sq5_r[0]) + SQ_IN_W'(sq5_r[1])
                 + SQ_IN_W'(sq5_r[2]) + SQ_IN_W'(sq5_r[3]);
    sb6_r.degen <= degen5_r;
    for (int c = 0; c < 4; c++) begin
      sb6_r.q[c] <= q5_r[c];
    end
  end

  // --------------------------------------------------------------------------
  // SQ2: vector length
  // --------------------------------------------------------------------------
  logic [SQ_OUT_W-1:0] root2;
  sqb_sb_t             sqb_dl_r [SQ_LAT];
  logic [SQ_LAT-1:0]   sqb_v_r;

  rmq_isqrt u_sq_len (
    .clk  (clk),
    .rad  (sum6_r),
    .root (root2)
  );

  always_ff @(posedge clk) begin
    sqb_dl_r[0] <= sb6_r;
    for (int k = 1; k < SQ_LAT; k++) begin
      sqb_dl_r[k] <= sqb_dl_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sqb_v_r <= '0;
    end else begin
      sqb_v_r <= {sqb_v_r[SQ_LAT-2:0], v6_r};
    end
  end

  // --------------------------------------------------------------------------
  // P7: zero-length check, feed the normalizing dividers
  // --------------------------------------------------------------------------
  logic                      v7_r;
  logic                      degen7_r;
  logic [DEN_W-1:0]          den7_r;
  logic signed [DIV_N_W-1:0] num7_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else begin
      v7_r <= sqb_v_r[SQ_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    degen7_r <= sqb_dl_r[SQ_LAT-1].degen || (root2 == '0);
    den7_r   <= DEN_W'(root2);
    for (int c = 0; c < 4; c++) begin
      num7_r[c] <= DIV_N_W'($signed(sqb_dl_r[SQ_LAT-1].q[c]));
    end
  end

  // --------------------------------------------------------------------------
  // DV2: normalize
  // --------------------------------------------------------------------------
  comp_t              quo2 [4];
  logic [DIV_LAT-1:0] dvb_deg_r;
  logic [DIV_LAT-1:0] dvb_v_r;

  for (genvar c = 0; c < 4; c++) begin : g_div_norm
    rmq_div u_div (
      .clk (clk),
      .num (num7_r[c]),
      .den (den7_r),
      .quo (quo2[c])
    );
  end

  always_ff @(posedge clk) begin
    dvb_deg_r <= {dvb_deg_r[DIV_LAT-2:0], degen7_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dvb_v_r <= '0;
    end else begin
      dvb_v_r <= {dvb_v_r[DIV_LAT-2:0], v7_r};
    end
  end

  // --------------------------------------------------------------------------
  // P8: canonical sign and result register
  // --------------------------------------------------------------------------
  comp_t                  lead;
  logic                   flip;
  comp_t                  fix [4];
  logic                   out_valid_r;
  logic                   out_deg_r;
  logic signed [OUT_W-1:0] out_q_r [4];

  // w leads; if w is zero, the first nonzero of x, y, z leads
  always_comb begin
    if (quo2[3] != '0) begin
      lead = quo2[3];
    end else if (quo2[0] != '0) begin
      lead = quo2[0];
    end else if (quo2[1] != '0) begin
      lead = quo2[1];
    end else begin
      lead = quo2[2];
    end
    flip = lead[Q_W-1];
    for (int c = 0; c < 4; c++) begin
      fix[c] = flip ? -quo2[c] : quo2[c];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dvb_v_r[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    out_deg_r <= dvb_deg_r[DIV_LAT-1];
    for (int c = 0; c < 4; c++) begin
      out_q_r[c] <= dvb_deg_r[DIV_LAT-1] ? '0 : OUT_W'(fix[c]);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_qx         = out_q_r[0];
  assign out_qy         = out_q_r[1];
  assign out_qz         = out_q_r[2];
  assign out_qw         = out_q_r[3];
  assign out_degenerate = out_deg_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // every accepted item produces its result strobe after the full pipeline latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##PIPE_LAT out_valid)
    else $error("accepted item did not produce a result on time");

  // no result without a matching item accepted the pipeline latency earlier
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, PIPE_LAT))
    else $error("result strobe without a matching item");

  // canonical form keeps w nonnegative
  a_qw_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_qw[OUT_W-1])
    else $error("scalar part negative after sign fix");

  // degenerate results carry all-zero components
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_degenerate) |->
      (out_qx == '0 && out_qy == '0 && out_qz == '0 && out_qw == '0))
    else $error("degenerate result with nonzero components");

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: rotation matrix to quaternion core
// Drives matrices through the command port (random start gaps in two of three
// phases), predicts each quaternion with an independent fixed-point model and
// compares every strobed result field by field, in order.
// ----------------------------------------------------------------------------
module testbench;
  import rmq_pkg::*;

  localparam int                 CLK_HALF    = 6;
  localparam int                 WATCH_LIMIT = 4 * PIPE_LAT + 2000;
  localparam logic [63:0]        ONE         = 64'd1 << FRAC_BITS;
  localparam logic signed [31:0] ONE_M       = 32'sd1 <<< FRAC_BITS;

  typedef struct packed {
    logic signed [31:0] qx, qy, qz, qw;
    logic               degen;
  } quat_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic signed [M_W-1:0]   m_in [9];
  logic                    out_valid;
  logic signed [OUT_W-1:0] out_qx, out_qy, out_qz, out_qw;
  logic                    out_degenerate;

  quat_t quat_pending[$];
  int    err_cnt = 0;
  int    idle_pct = 0;
  int    watch_cnt = 0;

  initial begin
    for (int i = 0; i < 9; i++) m_in[i] = '0;
  end

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  rotation_matrix_to_quaternion_core u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_m00(m_in[0]), .in_m01(m_in[1]), .in_m02(m_in[2]),
    .in_m10(m_in[3]), .in_m11(m_in[4]), .in_m12(m_in[5]),
    .in_m20(m_in[6]), .in_m21(m_in[7]), .in_m22(m_in[8]),
    .out_valid(out_valid), .out_qx(out_qx), .out_qy(out_qy),
    .out_qz(out_qz), .out_qw(out_qw), .out_degenerate(out_degenerate)
  );

  // Bitwise integer square root, floor.
  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res, bitv;
    res = '0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // (num * 2^F) / den, truncated toward zero.
  function automatic longint frac_div(longint num, logic [63:0] den);
    logic [63:0] mag, quo;
    mag = (num < 0) ? -num : num;
    quo = (mag << FRAC_BITS) / den;
    return (num < 0) ? -longint'(quo) : longint'(quo);
  endfunction

  function automatic quat_t predict_quat(logic signed [31:0] mx [9]);
    longint      m [3][3];
    longint      d [4];
    longint      q [4];
    longint      lead;
    logic [63:0] chosen, divisor, sq_sum, len, mag;
    int          ax, j, k;
    quat_t       r;
    for (int i = 0; i < 9; i++) m[i / 3][i % 3] = longint'(mx[i]);
    d[0] = longint'(ONE) + m[0][0] - m[1][1] - m[2][2];
    d[1] = longint'(ONE) - m[0][0] + m[1][1] - m[2][2];
    d[2] = longint'(ONE) - m[0][0] - m[1][1] + m[2][2];
    d[3] = longint'(ONE) + m[0][0] + m[1][1] + m[2][2];
    ax = AX_X;
    for (int i = 1; i < 4; i++) if (d[i] > d[ax]) ax = i;
    chosen = (d[ax] > 0) ? int_sqrt(64'(d[ax]) << (FRAC_BITS - 2)) : 64'd0;
    divisor = chosen << 2;
    for (int i = 0; i < 4; i++) q[i] = 0;
    r.degen = 1'b0;
    if (divisor == 0) begin
      r.degen = 1'b1;
    end else begin
      q[ax] = longint'(chosen);
      if (ax == AX_W) begin
        q[0] = frac_div(m[2][1] - m[1][2], divisor);
        q[1] = frac_div(m[0][2] - m[2][0], divisor);
        q[2] = frac_div(m[1][0] - m[0][1], divisor);
      end else begin
        j = (ax + 1) % 3;
        k = (ax + 2) % 3;
        q[j] = frac_div(m[j][ax] + m[ax][j], divisor);
        q[k] = frac_div(m[k][ax] + m[ax][k], divisor);
        q[3] = frac_div(m[k][j] - m[j][k], divisor);
      end
      sq_sum = '0;
      for (int i = 0; i < 4; i++) begin
        mag = (q[i] < 0) ? -q[i] : q[i];
        sq_sum += mag * mag;
      end
      len = int_sqrt(sq_sum);
      if (len == 0) begin
        r.degen = 1'b1;
        for (int i = 0; i < 4; i++) q[i] = 0;
      end else begin
        for (int i = 0; i < 4; i++) q[i] = frac_div(q[i], len);
        lead = q[3];
        for (int i = 0; i < 3; i++) if (lead == 0 && q[i] != 0) lead = q[i];
        if (lead < 0) for (int i = 0; i < 4; i++) q[i] = -q[i];
      end
    end
    r.qx = q[0][31:0];
    r.qy = q[1][31:0];
    r.qz = q[2][31:0];
    r.qw = q[3][31:0];
    return r;
  endfunction

  // Drive one matrix, hold start until the accept edge, then idle at random.
  task automatic send_matrix(logic signed [31:0] mx [9]);
    for (int i = 0; i < 9; i++) m_in[i] <= mx[i];
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    quat_pending = {quat_pending, predict_quat(mx)};
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
  endtask

  task automatic drop_start();
    start <= 1'b0;
    @(posedge clk);
  endtask

  // Check every strobed result against the oldest prediction.
  always @(posedge clk) begin
    quat_t exp_q;
    if (rst_n && out_valid) begin
      if (quat_pending.size() == 0) begin
        $display("%0t: unexpected result qx=%h qy=%h qz=%h qw=%h", $time,
                 out_qx, out_qy, out_qz, out_qw);
        err_cnt++;
      end else begin
        exp_q = quat_pending.pop_front();
        if (out_qx !== exp_q.qx) begin
          $display("%0t: qx expected %h actual %h", $time, exp_q.qx, out_qx);
          err_cnt++;
        end
        if (out_qy !== exp_q.qy) begin
          $display("%0t: qy expected %h actual %h", $time, exp_q.qy, out_qy);
          err_cnt++;
        end
        if (out_qz !== exp_q.qz) begin
          $display("%0t: qz expected %h actual %h", $time, exp_q.qz, out_qz);
          err_cnt++;
        end
        if (out_qw !== exp_q.qw) begin
          $display("%0t: qw expected %h actual %h", $time, exp_q.qw, out_qw);
          err_cnt++;
        end
        if (out_degenerate !== exp_q.degen) begin
          $display("%0t: degenerate expected %b actual %b", $time,
                   exp_q.degen, out_degenerate);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog: count cycles in which neither an item nor a result moves.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || !rst_n) begin
      watch_cnt <= 0;
    end else begin
      watch_cnt <= watch_cnt + 1;
      if (watch_cnt >= WATCH_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Rotation with small noise: built from a random quaternion scaled to unit length.
  function automatic void make_rotation(output logic signed [31:0] mx [9]);
    real a, b, c, w, x, y, z, n;
    a = $urandom_range(2000) - 1000.0;
    b = $urandom_range(2000) - 1000.0;
    c = $urandom_range(2000) - 1000.0;
    w = $urandom_range(2000) - 1000.0;
    n = $sqrt(a * a + b * b + c * c + w * w) + 1.0e-9;
    x = a / n; y = b / n; z = c / n; w = w / n;
    mx[0] = int'((1 - 2 * (y * y + z * z)) * 2.0 ** 30);
    mx[1] = int'((2 * (x * y - z * w)) * 2.0 ** 30);
    mx[2] = int'((2 * (x * z + y * w)) * 2.0 ** 30);
    mx[3] = int'((2 * (x * y + z * w)) * 2.0 ** 30);
    mx[4] = int'((1 - 2 * (x * x + z * z)) * 2.0 ** 30);
    mx[5] = int'((2 * (y * z - x * w)) * 2.0 ** 30);
    mx[6] = int'((2 * (x * z - y * w)) * 2.0 ** 30);
    mx[7] = int'((2 * (y * z + x * w)) * 2.0 ** 30);
    mx[8] = int'((1 - 2 * (x * x + y * y)) * 2.0 ** 30);
    for (int i = 0; i < 9; i++) mx[i] += $signed($urandom_range(64)) - 32;
  endfunction

  // Identity, each half-turn axis, ties, field extremes and the negative w path.
  task automatic test_directed();
    logic signed [31:0] mx [9];
    logic signed [31:0] ext [4];
    ext = '{32'sh7fffffff, 32'sh80000000, 32'sh0, -32'sh1};
    for (int ax = 0; ax < 4; ax++) begin
      for (int i = 0; i < 9; i++) mx[i] = '0;
      for (int i = 0; i < 3; i++) mx[i * 4] = (ax == 3 || ax == i) ? ONE_M : -ONE_M;
      send_matrix(mx);
    end
    // all-zero diagonal: four equal terms, the first must win
    for (int i = 0; i < 9; i++) mx[i] = '0;
    send_matrix(mx);
    for (int e = 0; e < 4; e++) begin
      for (int i = 0; i < 9; i++) mx[i] = ext[e];
      send_matrix(mx);
      for (int i = 0; i < 9; i++) mx[i] = (i % 2) ? ext[e] : ext[3 - e];
      send_matrix(mx);
    end
    // negative w path: rotation by more than a half turn about each axis
    for (int ax = 0; ax < 3; ax++) begin
      for (int i = 0; i < 9; i++) mx[i] = '0;
      mx[ax * 4] = ONE_M;
      mx[((ax + 1) % 3) * 4] = -ONE_M / 2;
      mx[((ax + 2) % 3) * 4] = -ONE_M / 2;
      mx[((ax + 1) % 3) * 3 + (ax + 2) % 3] = 32'sh60000000;
      mx[((ax + 2) % 3) * 3 + (ax + 1) % 3] = -32'sh60000000;
      send_matrix(mx);
    end
    drop_start();
  endtask

  // Mostly near-rotations, the rest raw bit patterns.
  task automatic test_random(int n_items);
    logic signed [31:0] mx [9];
    for (int n = 0; n < n_items; n++) begin
      if ($urandom_range(99) < 70) make_rotation(mx);
      else for (int i = 0; i < 9; i++) mx[i] = $urandom;
      send_matrix(mx);
    end
    drop_start();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    idle_pct = 37;
    test_random(450);
    idle_pct = 86;
    test_random(450);
    idle_pct = 0;
    test_random(450);
    // drain, then allow for stray strobes
    while (quat_pending.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 10) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
